// ----- src/rmvm_pkg.sv -----
// Package for the register/memory VM executor: opcodes, status codes, shared types.
// No dependencies.
package rmvm_pkg;

  localparam int unsigned KindW   = 5;
  localparam int unsigned RegIdxW = 8;
  localparam int unsigned WordW   = 64;
  localparam int unsigned OffW    = 32;
  localparam int unsigned StatW   = 3;
  localparam int unsigned SpW     = 11;

  localparam logic [StatW-1:0] ST_OK   = 3'd0;
  localparam logic [StatW-1:0] ST_REG  = 3'd1;
  localparam logic [StatW-1:0] ST_DIV0 = 3'd2;
  localparam logic [StatW-1:0] ST_MEM  = 3'd3;
  localparam logic [StatW-1:0] ST_OP   = 3'd4;

  localparam logic [KindW-1:0] OP_STD  = 5'd20;
  localparam logic [KindW-1:0] OP_LD   = 5'd23;
  localparam logic [KindW-1:0] OP_PUSH = 5'd28;
  localparam logic [KindW-1:0] OP_POP  = 5'd29;
  localparam logic [KindW-1:0] OP_LAST = 5'd29;

  // operation group
  localparam logic [2:0] GRP_ADD = 3'd0;
  localparam logic [2:0] GRP_SUB = 3'd1;
  localparam logic [2:0] GRP_MUL = 3'd2;
  localparam logic [2:0] GRP_DIV = 3'd3;
  localparam logic [2:0] GRP_ST  = 3'd4;
  localparam logic [2:0] GRP_LD  = 3'd5;
  localparam logic [2:0] GRP_PSH = 3'd6;
  localparam logic [2:0] GRP_POP = 3'd7;

  // operand form
  localparam logic [2:0] FRM_IMM = 3'd0;
  localparam logic [2:0] FRM_REG = 3'd1;
  localparam logic [2:0] FRM_DIR = 3'd2;
  localparam logic [2:0] FRM_IND = 3'd3;
  localparam logic [2:0] FRM_IDX = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] src_reg;
    logic [WordW-1:0]   immediate;
    logic [OffW-1:0]    index_offset;
  } instr_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [WordW-1:0] dest_value;
    logic [SpW-1:0]   stack_pointer;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture instruction, read registers
    logic addr;     // form address, issue memory read
    logic exec;     // check and start
    logic mul_stp;  // multiply partial step
    logic div_stp;  // divide step
    logic commit;   // write back and build result
    logic clear;    // memory clearing sweep
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic mul_done;
    logic div_done;
    logic clr_done;
  } dp_stat_t;

  // decode kind into group and form
  function automatic logic [5:0] decode(input logic [KindW-1:0] k);
    logic [2:0] g;
    logic [2:0] f;
    g = GRP_LD;
    f = FRM_IMM;
    if (k < 5'd5) begin
      g = GRP_ADD; f = 3'(k);
    end else if (k < 5'd10) begin
      g = GRP_SUB; f = 3'(k - 5'd5);
    end else if (k < 5'd15) begin
      g = GRP_MUL; f = 3'(k - 5'd10);
    end else if (k < 5'd20) begin
      g = GRP_DIV; f = 3'(k - 5'd15);
    end else if (k < OP_LD) begin
      g = GRP_ST; f = 3'(k - OP_STD + 5'd2);
    end else if (k < OP_PUSH) begin
      g = GRP_LD; f = 3'(k - OP_LD);
    end else if (k == OP_PUSH) begin
      g = GRP_PSH;
    end else begin
      g = GRP_POP;
    end
    return {g, f};
  endfunction

endpackage

// ----- src/rmvm_if.sv -----
// Valid/ready channel carrying one item of type T.
// No package dependency; the payload type is given by parameter T.
interface rmvm_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/rmvm_ctrl.sv -----
// Controller state machine for the VM executor: sequences each instruction.
// Depends on rmvm_pkg.
module rmvm_ctrl import rmvm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ADDR, S_EXEC, S_MUL, S_DIV, S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  // take a new item when idle and the result slot is free or draining
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = accept;
    cmd_o.addr    = (state_q == S_ADDR);
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.mul_stp = (state_q == S_MUL);
    cmd_o.div_stp = (state_q == S_DIV);
    cmd_o.commit  = (state_q == S_COMMIT);
    cmd_o.clear   = (state_q == S_CLEAR);
  end

  // hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR:  if (stat_i.clr_done) state_q <= S_IDLE;
        S_IDLE:   if (accept) state_q <= S_ADDR;
        S_ADDR:   state_q <= S_EXEC;
        S_EXEC: begin
          if (stat_i.need_mul)      state_q <= S_MUL;
          else if (stat_i.need_div) state_q <= S_DIV;
          else                      state_q <= S_COMMIT;
        end
        S_MUL:    if (stat_i.mul_done) state_q <= S_COMMIT;
        S_DIV:    if (stat_i.div_done) state_q <= S_COMMIT;
        S_COMMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/rmvm_dp.sv -----
// Datapath of the VM executor: register file, data memory, stack pointer,
// sequential multiplier and divider. Depends on rmvm_pkg.
module rmvm_dp import rmvm_pkg::*; #(
  parameter int unsigned NUM_REGS  = 16,
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  instr_t   instr_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output result_t  result_o
);

  localparam int unsigned RIW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned MAW  = $clog2(MEM_WORDS);
  // stack pointer holds 0..MEM_WORDS
  localparam int unsigned SPIW = $clog2(MEM_WORDS + 1);
  localparam logic [SPIW-1:0] SpEmpty = SPIW'(MEM_WORDS);

  // state
  logic [WordW-1:0] regs_q [NUM_REGS];
  logic [WordW-1:0] mem_q  [MEM_WORDS];
  logic [SPIW-1:0]  sp_q;

  // captured instruction
  instr_t           ins_q;
  logic [2:0]       grp_q, frm_q;
  logic [WordW-1:0] ra_q, rb_q;
  logic             a_ok_q, b_ok_q;
  logic [WordW-1:0] addr_q;
  logic             addr_ok_q;
  logic [WordW-1:0] mrd_q;
  logic [MAW-1:0]   clr_q;
  logic             clr_done_q;

  // execution results
  logic [StatW-1:0] st_q;
  logic             wr_reg_q, wr_mem_q;
  logic [WordW-1:0] wval_q;
  logic [SPIW-1:0]  sp_nx_q;
  logic [MAW-1:0]   waddr_q;
  result_t          res_q;

  // multiplier: three 32x32 partial products, one per step, then a result step
  logic [WordW-1:0] mul_acc_q;
  logic [1:0]       mul_cnt_q;
  // divider: restoring, one bit per step
  logic [WordW-1:0] dq_q, dr_q, dd_q;
  logic [6:0]       div_cnt_q;
  logic             dneg_q, dfin_q;

  logic [5:0]       dec;
  logic             a_ok, b_ok;
  logic [WordW-1:0] operand;
  logic [StatW-1:0] st_c;
  logic [31:0]      mx, my;
  logic [WordW-1:0] pp;
  logic [WordW:0]   trial;
  logic [WordW-1:0] rem_sh;
  logic [WordW-1:0] ua, ub;

  assign dec  = decode(instr_i.kind);
  assign a_ok = 32'(instr_i.dest_reg) < NUM_REGS;
  assign b_ok = 32'(instr_i.src_reg) < NUM_REGS;

  // select operand of the execute step
  always_comb begin
    case (frm_q)
      FRM_IMM: operand = ins_q.immediate;
      FRM_REG: operand = rb_q;
      default: operand = mrd_q;
    endcase
  end

  // status checks in priority order
  always_comb begin
    st_c = ST_OK;
    if (ins_q.kind > OP_LAST) st_c = ST_OP;
    else if (grp_q == GRP_PSH) begin
      if (sp_q == '0) st_c = ST_MEM;
      else if (!a_ok_q) st_c = ST_REG;
    end else if (grp_q == GRP_POP) begin
      if (sp_q >= SpEmpty) st_c = ST_MEM;
      else if (!a_ok_q) st_c = ST_REG;
    end else if (!a_ok_q) st_c = ST_REG;
    else if (frm_q != FRM_IMM && frm_q != FRM_DIR && !b_ok_q) st_c = ST_REG;
    else if (frm_q >= FRM_DIR && !addr_ok_q) st_c = ST_MEM;
    else if (grp_q == GRP_DIV && operand == '0) st_c = ST_DIV0;
  end

  assign stat_o.need_mul = (st_c == ST_OK) && (grp_q == GRP_MUL);
  assign stat_o.need_div = (st_c == ST_OK) && (grp_q == GRP_DIV);
  assign stat_o.mul_done = (mul_cnt_q == 2'd3);
  assign stat_o.div_done = dfin_q;
  assign stat_o.clr_done = clr_done_q;

  // partial product select
  always_comb begin
    mx = mul_cnt_q[0] ? ra_q[63:32] : ra_q[31:0];
    my = (mul_cnt_q == 2'd0 || mul_cnt_q == 2'd1) ? operand[31:0] : operand[63:32];
  end
  assign pp = mx * my;

  assign ua = ra_q[63] ? (~ra_q + 64'd1) : ra_q;
  assign ub = operand[63] ? (~operand + 64'd1) : operand;
  assign rem_sh = {dr_q[62:0], dq_q[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dd_q};

  // front end: capture, register read, address and memory read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ins_q  <= instr_i;
      grp_q  <= dec[5:3];
      frm_q  <= dec[2:0];
      a_ok_q <= a_ok;
      b_ok_q <= b_ok;
      ra_q   <= a_ok ? regs_q[instr_i.dest_reg[RIW-1:0]] : '0;
      rb_q   <= b_ok ? regs_q[instr_i.src_reg[RIW-1:0]] : '0;
    end
    if (cmd_i.addr) begin
      logic [WordW-1:0] ad;
      ad = '0;
      if (grp_q == GRP_POP) ad = WordW'(sp_q);
      else if (frm_q == FRM_DIR) ad = ins_q.immediate;
      else if (frm_q == FRM_IND) ad = rb_q;
      else if (frm_q == FRM_IDX)
        ad = rb_q + {{(WordW-OffW){ins_q.index_offset[OffW-1]}}, ins_q.index_offset};
      addr_q    <= ad;
      addr_ok_q <= ad < WordW'(MEM_WORDS);
      mrd_q     <= mem_q[ad[MAW-1:0]];
    end
  end

  // execute, multiply and divide sequencing
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      st_q      <= st_c;
      wr_reg_q  <= 1'b0;
      wr_mem_q  <= 1'b0;
      sp_nx_q   <= sp_q;
      wval_q    <= ra_q;
      waddr_q   <= addr_q[MAW-1:0];
      mul_acc_q <= '0;
      mul_cnt_q <= '0;
      dq_q      <= ua;
      dr_q      <= '0;
      dd_q      <= ub;
      dneg_q    <= ra_q[63] ^ operand[63];
      div_cnt_q <= '0;
      dfin_q    <= 1'b0;
      if (st_c == ST_OK) begin
        case (grp_q)
          GRP_ADD: begin wr_reg_q <= 1'b1; wval_q <= ra_q + operand; end
          GRP_SUB: begin wr_reg_q <= 1'b1; wval_q <= ra_q - operand; end
          GRP_MUL: wr_reg_q <= 1'b1;
          GRP_DIV: wr_reg_q <= 1'b1;
          GRP_ST:  wr_mem_q <= 1'b1;
          GRP_LD:  begin wr_reg_q <= 1'b1; wval_q <= operand; end
          GRP_PSH: begin
            wr_mem_q <= 1'b1;
            sp_nx_q  <= sp_q - 1'b1;
            waddr_q  <= MAW'(sp_q - 1'b1);
          end
          default: begin
            wr_reg_q <= 1'b1;
            wval_q   <= mrd_q;
            sp_nx_q  <= sp_q + 1'b1;
          end
        endcase
      end
    end
    if (cmd_i.mul_stp) begin
      case (mul_cnt_q)
        2'd0:    mul_acc_q <= pp;
        2'd3:    wval_q <= mul_acc_q;
        default: mul_acc_q <= mul_acc_q + {pp[31:0], 32'd0};
      endcase
      mul_cnt_q <= mul_cnt_q + 2'd1;
    end
    if (cmd_i.div_stp) begin
      if (div_cnt_q == 7'd64) begin
        wval_q <= dneg_q ? (~dq_q + 64'd1) : dq_q;
        dfin_q <= 1'b1;
      end else begin
        if (!trial[WordW]) begin
          dr_q <= trial[WordW-1:0];
          dq_q <= {dq_q[62:0], 1'b1};
        end else begin
          dr_q <= rem_sh;
          dq_q <= {dq_q[62:0], 1'b0};
        end
        div_cnt_q <= div_cnt_q + 7'd1;
      end
    end
  end

  // register file and stack pointer write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
      sp_q <= SpEmpty;
    end else if (cmd_i.commit) begin
      if (wr_reg_q) regs_q[ins_q.dest_reg[RIW-1:0]] <= wval_q;
      sp_q <= sp_nx_q;
    end
  end

  // data memory: clearing sweep after reset, then stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) mem_q[clr_q] <= '0;
    else if (cmd_i.commit && wr_mem_q) mem_q[waddr_q] <= ra_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == MAW'(MEM_WORDS - 1)) clr_done_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.status        <= st_q;
      res_q.dest_value    <= a_ok_q ? (wr_reg_q ? wval_q : ra_q) : '0;
      res_q.stack_pointer <= SpW'(sp_nx_q);
    end
  end
  assign result_o = res_q;

endmodule

// ----- src/register_memory_vm_executor.sv -----
// Register/memory VM executor, top level.
// Sequence per item: register read at accept, address and memory read, execute, then write-back;
// MUL and DIV add the multiplier and divider steps before write-back. A new item is accepted
// only when idle after write-back and the result slot is free or draining; the divider iterates bitwise.
// Reset: registers zero, stack empty; a clearing pass then zeroes the data memory,
// and no item is accepted until it ends.
module register_memory_vm_executor import rmvm_pkg::*; #(
  parameter int unsigned NUM_REGS  = 16,
  parameter int unsigned MEM_WORDS = 1024
) (
  input logic    clk_i,
  input logic    rst_ni,
  rmvm_if.sink   in_i,
  rmvm_if.source out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rmvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmvm_dp #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .instr_i  (in_i.data),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (out_o.data)
  );

  // no item taken while the memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !in_i.ready) else $error("item accepted during clear");

  // a commit raises result valid in the next cycle
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid) else $error("result lost after commit");

  // an accept, an execute and a commit never coincide
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.commit, cmd.exec})) else $error("overlapping items");

endmodule
